### rtl/core/rdc_pkg.sv
`default_nettype none
package rdc_pkg;

   localparam int POS_BITS       = 15;
   localparam int IN_VALUE_BITS  = 16;
   localparam int TAG_BITS       = 18;
   localparam int COUNT_BITS     = 16;
   localparam int DEF_ARRAY_DEPTH = 32768;
   localparam int DEF_VALUE_BITS  = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic lookup;
      logic update;
      logic add;
   } freq_ctrl_type;

endpackage
`default_nettype wire

### rtl/core/rdc_req_if.sv
`default_nettype none
interface rdc_req_if;
   import rdc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [POS_BITS-1:0]      index;
   logic [IN_VALUE_BITS-1:0] value;
   logic [POS_BITS-1:0]      left;
   logic [POS_BITS-1:0]      right;
   logic [TAG_BITS-1:0]      tag;

   modport source (output valid, op, index, value, left, right, tag, input ready);
   modport sink   (input valid, op, index, value, left, right, tag, output ready);
endinterface
`default_nettype wire

### rtl/core/rdc_rsp_if.sv
`default_nettype none
interface rdc_rsp_if;
   import rdc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TAG_BITS-1:0]   answer_tag;
   logic [COUNT_BITS-1:0] distinct_count;
   logic                  bad_range;

   modport source (output valid, answer_tag, distinct_count, bad_range, input ready);
   modport sink   (input valid, answer_tag, distinct_count, bad_range, output ready);
endinterface
`default_nettype wire

### rtl/core/range_distinct_count_window.sv
// range_distinct_count_window
//
// Keeps an element array and a moving window [left, right] over it, and
// answers how many distinct values lie in a requested range.
// req channel (valid/ready): op = load writes value at index, no response;
// op = query moves the window to [left, right] and returns one response.
// rsp channel (valid/ready): answer_tag, distinct_count, bad_range.
// A query with left above right returns bad_range = 1 and count 0 and
// leaves the window as it was. A right bound past the array saturates.
// Each window edge step is an element array read, then a
// read-modify-write of the per-value count table. A query makes one step
// per element added or removed; a load outside the window is written as
// it is taken, a load inside it removes the old value, then adds the new.
// The block takes one request at a time; a finished response sits in an
// output register, so a new request is taken while the receiver stalls.
// A further query waits for that register only when it is done itself.
// After reset the count table is cleared, one entry a cycle, over all
// 2**VALUE_BITS entries; req ready stays low until the pass ends.
`default_nettype none
module range_distinct_count_window #(
   parameter int ARRAY_DEPTH = rdc_pkg::DEF_ARRAY_DEPTH,
   parameter int VALUE_BITS  = rdc_pkg::DEF_VALUE_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   rdc_req_if.sink   req_bus,
   rdc_rsp_if.source rsp_bus
);
   import rdc_pkg::*;

   localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(ARRAY_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_FIRST, ST_COUNT, ST_UPDATE, ST_DONE
   } state_type;

   state_type             state_ff;
   logic [POS_BITS-1:0]   ql_ff, qr_ff, qidx_ff, pos_ff;
   logic [POS_BITS-1:0]   wl_ff, wr_ff;
   logic                  empty_ff;
   logic [VALUE_BITS-1:0] qval_ff;
   logic [TAG_BITS-1:0]   qtag_ff;
   logic                  bad_ff, load_ff, use_new_ff, add_ff;
   logic [1:0]            phase_ff;
   logic                  rsp_valid_ff;
   logic [TAG_BITS-1:0]   rsp_tag_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_bad_ff;

   logic [VALUE_BITS-1:0] elem_mem_ff [ARRAY_DEPTH];
   logic [VALUE_BITS-1:0] elem_rdata_ff;
   logic [AW-1:0]         elem_raddr;
   logic                  elem_we;
   logic [AW-1:0]         elem_waddr;
   logic [VALUE_BITS-1:0] elem_wdata;

   freq_ctrl_type         fctrl;
   logic [VALUE_BITS-1:0] fvalue;
   logic                  fbusy;
   logic [COUNT_BITS-1:0] distinct;

   logic                  req_fire;
   logic [POS_BITS-1:0]   right_sat;
   logic                  idx_ok, in_window;

   logic [POS_BITS-1:0]   seg_start [4];
   logic [POS_BITS-1:0]   seg_stop  [4];
   logic [3:0]            seg_ok;
   logic [2:0]            pick_base;
   logic [1:0]            pick;
   logic                  pick_found;
   logic                  step_last;
   logic                  has_next;
   logic [POS_BITS-1:0]   next_pos;
   logic [1:0]            next_phase;

   rdc_freq #(.VALUE_BITS(VALUE_BITS)) u_freq (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (fctrl),
      .value    (fvalue),
      .busy     (fbusy),
      .distinct (distinct)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);

   assign right_sat = ({17'd0, req_bus.right} >= 32'(ARRAY_DEPTH)) ? LAST_POS : req_bus.right;
   assign idx_ok    = {17'd0, req_bus.index} < 32'(ARRAY_DEPTH);
   assign in_window = !empty_ff && (req_bus.index >= wl_ff) && (req_bus.index <= wr_ff);

   // window edge segments: grow left, grow right, shrink left, shrink right
   always_comb begin
      seg_start[0] = ql_ff;
      seg_stop[0]  = empty_ff ? qr_ff : wl_ff - POS_BITS'(1);
      seg_ok[0]    = empty_ff || (ql_ff < wl_ff);
      seg_start[1] = wr_ff + POS_BITS'(1);
      seg_stop[1]  = qr_ff;
      seg_ok[1]    = !empty_ff && (qr_ff > wr_ff);
      seg_start[2] = wl_ff;
      seg_stop[2]  = ql_ff - POS_BITS'(1);
      seg_ok[2]    = !empty_ff && (ql_ff > wl_ff);
      seg_start[3] = qr_ff + POS_BITS'(1);
      seg_stop[3]  = wr_ff;
      seg_ok[3]    = !empty_ff && (wr_ff > qr_ff);
   end

   always_comb begin
      step_last  = (pos_ff == seg_stop[phase_ff]);
      pick_base  = (state_ff == ST_FIRST) ? 3'd0 : {1'b0, phase_ff} + 3'd1;
      pick       = 2'd0;
      pick_found = 1'b0;
      for (int j = 3; j >= 0; j--) begin
         if (3'(j) >= pick_base && seg_ok[j]) begin
            pick       = 2'(j);
            pick_found = 1'b1;
         end
      end
      if (state_ff == ST_UPDATE && !step_last) begin
         has_next   = 1'b1;
         next_pos   = pos_ff + POS_BITS'(1);
         next_phase = phase_ff;
      end else begin
         has_next   = pick_found;
         next_pos   = seg_start[pick];
         next_phase = pick;
      end
   end

   always_comb begin
      fctrl.lookup = (state_ff == ST_COUNT);
      fctrl.update = (state_ff == ST_UPDATE);
      fctrl.add    = add_ff;
      fvalue       = use_new_ff ? qval_ff : elem_rdata_ff;

      elem_raddr = AW'(next_pos);
      if (state_ff == ST_IDLE) begin
         elem_raddr = AW'(req_bus.index);
      end

      elem_we    = 1'b0;
      elem_waddr = AW'(qidx_ff);
      elem_wdata = qval_ff;
      if (req_fire && req_bus.op == OP_LOAD && idx_ok && !in_window) begin
         elem_we    = 1'b1;
         elem_waddr = AW'(req_bus.index);
         elem_wdata = VALUE_BITS'(req_bus.value);
      end else if (state_ff == ST_UPDATE && load_ff && !use_new_ff) begin
         elem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem_ff[elem_waddr] <= elem_wdata;
      end
      elem_rdata_ff <= elem_mem_ff[elem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wl_ff        <= '0;
         wr_ff        <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         load_ff      <= 1'b0;
         use_new_ff   <= 1'b0;
         add_ff       <= 1'b0;
         phase_ff     <= '0;
         pos_ff       <= '0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff) inside
            ST_CLEAR: begin
               if (!fbusy) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  qidx_ff <= req_bus.index;
                  qval_ff <= VALUE_BITS'(req_bus.value);
                  qtag_ff <= req_bus.tag;
                  ql_ff   <= req_bus.left;
                  qr_ff   <= right_sat;
                  if (req_bus.op == OP_LOAD) begin
                     if (idx_ok && in_window) begin
                        load_ff    <= 1'b1;
                        use_new_ff <= 1'b0;
                        add_ff     <= 1'b0;
                        state_ff   <= ST_COUNT;
                     end
                  end else begin
                     load_ff    <= 1'b0;
                     use_new_ff <= 1'b0;
                     bad_ff     <= (req_bus.left > right_sat);
                     state_ff   <= (req_bus.left > right_sat) ? ST_DONE : ST_FIRST;
                  end
               end
            end
            ST_FIRST, ST_UPDATE: begin
               if (load_ff) begin
                  if (use_new_ff) begin
                     load_ff    <= 1'b0;
                     use_new_ff <= 1'b0;
                     state_ff   <= ST_IDLE;
                  end else begin
                     use_new_ff <= 1'b1;
                     add_ff     <= 1'b1;
                     state_ff   <= ST_COUNT;
                  end
               end else if (has_next) begin
                  pos_ff   <= next_pos;
                  phase_ff <= next_phase;
                  add_ff   <= (next_phase < 2'd2);
                  state_ff <= ST_COUNT;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_COUNT: begin
               state_ff <= ST_UPDATE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_tag_ff   <= qtag_ff;
                  rsp_count_ff <= bad_ff ? '0 : distinct;
                  rsp_bad_ff   <= bad_ff;
                  if (!bad_ff) begin
                     wl_ff    <= ql_ff;
                     wr_ff    <= qr_ff;
                     empty_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.answer_tag     = rsp_tag_ff;
   assign rsp_bus.distinct_count = rsp_count_ff;
   assign rsp_bus.bad_range      = rsp_bad_ff;

   a_window_ordered: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> wl_ff <= wr_ff)
      else $error("window bounds out of order");

   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      fbusy |-> !req_bus.ready)
      else $error("request taken during clearing pass");

   a_response_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule
`default_nettype wire

### rtl/core/rdc_freq.sv
`default_nettype none
module rdc_freq #(
   parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rdc_pkg::freq_ctrl_type          ctrl,
   input  wire logic [VALUE_BITS-1:0]           value,
   output logic                                 busy,
   output logic [rdc_pkg::COUNT_BITS-1:0]       distinct
);
   import rdc_pkg::*;

   localparam int VALUE_RANGE = 2 ** VALUE_BITS;

   logic [COUNT_BITS-1:0] cnt_mem_ff [VALUE_RANGE];
   logic [COUNT_BITS-1:0] cnt_rdata_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] clr_addr_ff;
   logic                  busy_ff;
   logic [COUNT_BITS-1:0] distinct_ff;
   logic [COUNT_BITS-1:0] distinct_in;

   logic                  cnt_we;
   logic [VALUE_BITS-1:0] cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;

   always_comb begin
      cnt_we      = 1'b0;
      cnt_waddr   = val_ff;
      cnt_wdata   = cnt_rdata_ff;
      distinct_in = distinct_ff;
      if (busy_ff) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_addr_ff;
         cnt_wdata = '0;
      end else if (ctrl.update) begin
         if (ctrl.add) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata_ff + COUNT_BITS'(1);
            if (cnt_rdata_ff == '0) begin
               distinct_in = distinct_ff + COUNT_BITS'(1);
            end
         end else if (cnt_rdata_ff != '0) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata_ff - COUNT_BITS'(1);
            if (cnt_rdata_ff == COUNT_BITS'(1) && distinct_ff != '0) begin
               distinct_in = distinct_ff - COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      if (ctrl.lookup) begin
         cnt_rdata_ff <= cnt_mem_ff[value];
         val_ff       <= value;
      end
   end

   // clearing pass over the count table after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
         distinct_ff <= '0;
      end else begin
         distinct_ff <= distinct_in;
         if (busy_ff) begin
            clr_addr_ff <= clr_addr_ff + VALUE_BITS'(1);
            if (clr_addr_ff == '1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign distinct = distinct_ff;

   a_no_access_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctrl.lookup && !ctrl.update)
      else $error("count table accessed during clearing pass");

   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      ctrl.lookup |=> ctrl.update)
      else $error("count lookup not followed by update");

   a_update_after_lookup: assert property (@(posedge clock) disable iff (reset)
      ctrl.update |-> $past(ctrl.lookup))
      else $error("count update without preceding lookup");

endmodule
`default_nettype wire

### sim/rdc_answer_checker.sv
`timescale 1ns / 1ps
module rdc_answer_checker (
   input  logic        clock,
   input  logic        reset,
   rdc_req_if          req_bus,
   rdc_rsp_if          rsp_bus,
   output int unsigned fault_count,
   output int unsigned answers_open
);
   import rdc_pkg::*;

   localparam int ELEM_DEPTH = DEF_ARRAY_DEPTH;
   localparam int VALUE_SPAN = 1 << DEF_VALUE_BITS;

   typedef struct packed {
      logic [TAG_BITS-1:0]   tag;
      logic [COUNT_BITS-1:0] count;
      logic                  bad;
   } answer_type;

   bit [IN_VALUE_BITS-1:0] elem_mem [ELEM_DEPTH];
   int unsigned            value_hits [VALUE_SPAN];
   int unsigned            distinct_now = 0;
   int unsigned            win_lo = 0;
   int unsigned            win_hi = 0;
   bit                     win_void = 1'b1;
   answer_type             answers_due [$];
   int unsigned            faults = 0;

   assign fault_count = faults;

   function automatic void take_in(int unsigned pos);
      int unsigned v;
      v = elem_mem[pos % ELEM_DEPTH];
      value_hits[v]++;
      if (value_hits[v] == 1) begin
         distinct_now++;
      end
   endfunction

   function automatic void take_out(int unsigned pos);
      int unsigned v;
      v = elem_mem[pos % ELEM_DEPTH];
      if (value_hits[v] == 0) begin
         return;
      end
      value_hits[v]--;
      if (value_hits[v] == 0 && distinct_now > 0) begin
         distinct_now--;
      end
   endfunction

   task automatic predict_distinct(input logic op, input logic [POS_BITS-1:0] index,
                                   input logic [IN_VALUE_BITS-1:0] value,
                                   input logic [POS_BITS-1:0] left,
                                   input logic [POS_BITS-1:0] right,
                                   input logic [TAG_BITS-1:0] tag);
      int unsigned lo;
      int unsigned hi;
      int unsigned i;
      answer_type  due;
      lo = left;
      hi = right;
      if (op == OP_LOAD) begin
         if (index >= ELEM_DEPTH) begin
            return;
         end
         if (!win_void && index >= win_lo && index <= win_hi) begin
            take_out(index);
            elem_mem[index] = value;
            take_in(index);
         end else begin
            elem_mem[index] = value;
         end
         return;
      end
      if (hi >= ELEM_DEPTH) begin
         hi = ELEM_DEPTH - 1;
      end
      due.tag = tag;
      if (lo > hi) begin
         due.count = '0;
         due.bad = 1'b1;
      end else begin
         if (win_void) begin
            for (i = lo; i <= hi; i++) take_in(i);
         end else begin
            // grow first, then shrink
            for (i = lo; i < win_lo; i++) take_in(i);
            for (i = win_hi + 1; i <= hi; i++) take_in(i);
            for (i = win_lo; i < lo; i++) take_out(i);
            for (i = hi + 1; i <= win_hi; i++) take_out(i);
         end
         win_lo = lo;
         win_hi = hi;
         win_void = 1'b0;
         due.count = distinct_now[COUNT_BITS-1:0];
         due.bad = 1'b0;
      end
      answers_due.push_back(due);
   endtask

   task automatic report_mismatch(input string what, input answer_type got,
                                  input answer_type want);
      $display("%0t %s: tag %0d/%0d count %0d/%0d bad_range %b/%b (got/expected)",
               $time, what, got.tag, want.tag, got.count, want.count, got.bad, want.bad);
      faults++;
   endtask

   always @(posedge clock) begin
      answer_type got;
      answer_type due;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.tag = rsp_bus.answer_tag;
            got.count = rsp_bus.distinct_count;
            got.bad = rsp_bus.bad_range;
            if (answers_due.size() == 0) begin
               report_mismatch("answer with no query outstanding", got, '0);
            end else begin
               due = answers_due.pop_front();
               if (got.tag !== due.tag || got.count !== due.count || got.bad !== due.bad) begin
                  report_mismatch("answer mismatch", got, due);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_distinct(req_bus.op, req_bus.index, req_bus.value, req_bus.left,
                             req_bus.right, req_bus.tag);
         end
      end
      answers_open <= answers_due.size();
   end

endmodule

### sim/range_distinct_count_window_tb.sv
`timescale 1ns / 1ps
module range_distinct_count_window_tb;
   import rdc_pkg::*;

   localparam int          RANDOM_ITEMS = 800;
   localparam int          SPAN_CAP     = 256;
   localparam int unsigned POS_MAX      = (1 << POS_BITS) - 1;
   localparam int unsigned TAG_MAX      = (1 << TAG_BITS) - 1;
   localparam int unsigned SEAM         = 32'h4000;

   typedef enum {SINK_OPEN, SINK_RANDOM, SINK_HICCUP, SINK_TRICKLE} sink_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned fault_count;
   int unsigned answers_open;

   int unsigned burst_left = 0;
   int unsigned span_lo = 0;
   int unsigned span_hi = 0;
   int unsigned win_lo = 0;
   int unsigned win_hi = 0;
   bit          have_window = 1'b0;
   int unsigned loads_sent = 0;
   int unsigned queries_sent = 0;
   int unsigned bad_sent = 0;
   int unsigned drains = 0;

   sink_mode_type sink_mode = SINK_OPEN;
   int unsigned   sink_phase = 0;
   int unsigned   sink_period = 2;

   rdc_req_if req_bus ();
   rdc_rsp_if rsp_bus ();

   range_distinct_count_window dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rdc_answer_checker answer_check (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .fault_count  (fault_count),
      .answers_open (answers_open)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (sink_phase == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_period = $urandom_range(2, 12);
         sink_phase = $urandom_range(100, 400);
      end
      sink_phase--;
      case (sink_mode)
         SINK_OPEN: begin
            rsp_bus.ready <= 1'b1;
         end
         SINK_RANDOM: begin
            rsp_bus.ready <= ($urandom_range(0, 99) < 60);
         end
         SINK_HICCUP: begin
            rsp_bus.ready <= (sink_phase % sink_period) != 0;
         end
         default: begin
            rsp_bus.ready <= (sink_phase % sink_period) == 0;
         end
      endcase
   end

   task automatic send_request(input logic op, input int unsigned index, input int unsigned value,
                               input int unsigned left, input int unsigned right,
                               input int unsigned tag);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.index <= POS_BITS'(index);
      req_bus.value <= IN_VALUE_BITS'(value);
      req_bus.left  <= POS_BITS'(left);
      req_bus.right <= POS_BITS'(right);
      req_bus.tag   <= TAG_BITS'(tag);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_load(input int unsigned index, input int unsigned value);
      send_request(OP_LOAD, index, value, $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
                   $urandom_range(0, TAG_MAX));
      loads_sent++;
   endtask

   task automatic send_query(input int unsigned left, input int unsigned right,
                             input int unsigned tag);
      send_request(OP_QUERY, $urandom_range(0, POS_MAX), $urandom_range(0, 16'hFFFF),
                   left, right, tag);
      queries_sent++;
      if (left > right) begin
         bad_sent++;
      end else begin
         win_lo = left;
         win_hi = right;
         have_window = 1'b1;
      end
   endtask

   task automatic drain_answers();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (answers_open != 0);
      drains++;
   endtask

   function automatic int unsigned pick_value();
      case ($urandom_range(0, 9))
         0: return 16'hFFFF;
         1, 2: return $urandom_range(0, 16'hFFFF);
         default: return $urandom_range(0, 11);
      endcase
   endfunction

   function automatic int unsigned nudge(input int unsigned pos);
      int p;
      p = int'(pos) + int'($urandom_range(0, 12)) - 6;
      if (p < int'(span_lo)) p = span_lo;
      if (p > int'(span_hi)) p = span_hi;
      return p;
   endfunction

   task automatic random_load();
      int unsigned pick;
      int unsigned pos;
      pick = $urandom_range(0, 99);
      if (pick < 35 && span_hi - span_lo + 1 < SPAN_CAP) begin
         // grow the fully written stretch by one position
         if (($urandom_range(0, 1) == 0 && span_lo > 0) || span_hi == POS_MAX) begin
            span_lo--;
            pos = span_lo;
         end else begin
            span_hi++;
            pos = span_hi;
         end
      end else if (pick < 80) begin
         if (have_window && $urandom_range(0, 1) == 1) begin
            pos = $urandom_range(win_lo, win_hi);
         end else begin
            pos = $urandom_range(span_lo, span_hi);
         end
      end else begin
         pos = $urandom_range(0, POS_MAX);
      end
      send_load(pos, pick_value());
   endtask

   task automatic random_query();
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      int unsigned swap;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         lo = $urandom_range(1, POS_MAX);
         hi = $urandom_range(0, lo - 1);
      end else if (pick < 70 && have_window) begin
         lo = nudge(win_lo);
         hi = nudge(win_hi);
         if (lo > hi && $urandom_range(0, 3) != 0) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
      end else begin
         lo = $urandom_range(span_lo, span_hi);
         hi = lo + $urandom_range(0, 48);
         if (hi > span_hi) hi = span_hi;
      end
      send_query(lo, hi, $urandom_range(0, TAG_MAX));
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_LOAD;
      req_bus.index = '0;
      req_bus.value = '0;
      req_bus.left = '0;
      req_bus.right = '0;
      req_bus.tag = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_query(POS_MAX, 0, 0);
      send_query(1, 0, TAG_MAX);
      send_load(0, 0);
      send_load(POS_MAX, 16'hFFFF);
      // written stretch straddles 0x4000 so every position bit toggles
      for (int i = 0; i < 16; i++) begin
         send_load(SEAM - 8 + i, (i == 0) ? 16'hFFFF : (i == 15) ? 0 : i % 5);
      end
      span_lo = SEAM - 8;
      span_hi = SEAM + 7;
      send_query(SEAM - 8, SEAM - 8, 1);
      send_query(SEAM - 8, SEAM + 7, 2);
      send_load(SEAM, 16'hFFFF);
      send_load(SEAM - 8, 7);
      send_load(SEAM + 7, 16'hFFFF);
      send_query(SEAM - 8, SEAM + 7, 3);
      send_query(SEAM - 4, SEAM + 3, 4);
      send_query(SEAM - 7, SEAM + 3, 5);
      send_query(SEAM - 7, SEAM + 6, 6);
      send_query(SEAM, SEAM, 7);
      send_query(SEAM + 5, SEAM + 4, 8);
      send_query(SEAM, SEAM, 9);
      send_load(SEAM + 6, 3);
      send_query(SEAM - 8, SEAM + 7, 10);
      send_query(SEAM + 2, SEAM + 7, 11);
      send_query(SEAM - 8, SEAM - 3, 12);
      drain_answers();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 2) begin
            drain_answers();
         end
         if ($urandom_range(0, 1) == 0) begin
            random_load();
         end else begin
            random_query();
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (answers_open != 0);
      repeat (20) @(posedge clock);
      $display("covered %0d loads and %0d queries, %0d of them with left above right",
               loads_sent, queries_sent, bad_sent);
      $display("window moved over %0d written positions, pipeline drained %0d times",
               span_hi - span_lo + 1, drains);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
rtl/core/rdc_pkg.sv
rtl/core/rdc_req_if.sv
rtl/core/rdc_rsp_if.sv
rtl/core/rdc_freq.sv
rtl/core/range_distinct_count_window.sv
sim/rdc_answer_checker.sv
sim/range_distinct_count_window_tb.sv
